[rtl/cpra_pkg.sv]
// cpra_pkg: shared types, codes and defaults for the contiguous page run allocator.
// No dependencies; imported by the allocator top level.
`timescale 1ns / 1ps
`default_nettype none

package cpra_pkg;

    // Defaults for the top-level parameters
    localparam int CPRA_ZONE_PAGES = 4096;
    localparam int CPRA_PAGE_BYTES = 4096;

    // Bitmap row width held in one RAM word
    localparam int WORD_BITS = 8;

    // Field widths of the request and response words
    localparam int REQ_TYPE_W = 2;
    localparam int COUNT_W    = 13;
    localparam int ADDR_W     = 48;
    localparam int STATUS_W   = 2;
    localparam int RUN_ADDR_W = 24;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [COUNT_W-1:0]    page_count;
        logic [ADDR_W-1:0]     byte_address;
    } cpra_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  page_in_use;
        logic [RUN_ADDR_W-1:0] run_address;
    } cpra_rsp_t;

endpackage

`default_nettype wire

[rtl/cpra_ram.sv]
// cpra_ram: generic simple dual-port RAM, one write port, one registered read port.
// Standalone; used for the page usage bitmap.
`timescale 1ns / 1ps
`default_nettype none

module cpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire                                     clk,
    input  wire                                     we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                        wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/contiguous_page_run_allocator.sv]
// contiguous_page_run_allocator: first-fit page run allocator over a bitmap in RAM.
// The word walks take one bitmap word (8 pages) per cycle through the single RAM read port.
// One request at a time; a new request is taken once the previous one has finished.
// Reset: a clearing pass writes every bitmap word (ceil(ZONE_PAGES/8), 512 at defaults),
// leaving page 0 reserved; req_stall stays high until it ends.
// Depends on cpra_pkg and cpra_ram.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_page_run_allocator
    import cpra_pkg::*;
#(
    parameter int ZONE_PAGES = CPRA_ZONE_PAGES,
    parameter int PAGE_BYTES = CPRA_PAGE_BYTES
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_stall,
    input  wire cpra_req_t req_data,
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output cpra_rsp_t      rsp_data
);

    // Geometry derived from the zone size and page size
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int NUM_WORDS  = (ZONE_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int PGW        = AW + BW;             // page index width
    localparam int FW         = ADDR_W - PAGE_SHIFT; // page number width of a byte address
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLEAR  = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_RMW    = 7'b0010000,
        S_QBIT   = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [REQ_TYPE_W-1:0] req_reg, req_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [FW-1:0]         first_reg, first_next;
    // word pointer: read issue side, and the word whose data is on the RAM output
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  ev_vld_reg, ev_vld_next;
    logic [AW-1:0]         ev_ptr_reg, ev_ptr_next;
    // first-fit run tracking across words
    logic [COUNT_W-1:0]    run_reg, run_next;
    logic [PGW-1:0]        start_reg, start_next;
    // page range of the read-modify-write pass; set_reg selects mark (1) or clear (0)
    logic [PGW-1:0]        fp_reg, fp_next;
    logic [PGW-1:0]        lp_reg, lp_next;
    logic                  set_reg, set_next;
    cpra_rsp_t             rsp_reg, rsp_next;
    logic                  out_vld_reg, out_vld_next;
    cpra_rsp_t             out_data_reg, out_data_next;

    // Bitmap RAM
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    cpra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Range checks on the latched page number
    logic [FW:0] last_page;
    logic        first_out;
    logic        last_out;

    assign last_page = {1'b0, first_reg} + (FW+1)'(count_reg) - (FW+1)'(1);
    assign first_out = (first_reg >= FW'(ZONE_PAGES));
    assign last_out  = (last_page >= (FW+1)'(ZONE_PAGES));

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_data_reg;

    always_comb
    begin
        logic [COUNT_W-1:0] run_v;
        logic [PGW-1:0]     start_v;
        logic               hit_v;
        logic [PGW-1:0]     hit_start_v;
        logic [PGW-1:0]     hit_page_v;
        logic [PGW-1:0]     page_v;
        logic [WORD_BITS-1:0] mask_v;
        logic [63:0]        addr_wide_v;
        logic [AW-1:0]      end_word_v;

        state_next      = state_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        ptr_next        = ptr_reg;
        issue_done_next = issue_done_reg;
        ev_vld_next     = 1'b0;
        ev_ptr_next     = ev_ptr_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        fp_next         = fp_reg;
        lp_next         = lp_reg;
        set_next        = set_reg;
        rsp_next        = rsp_reg;
        out_vld_next    = out_vld_reg;
        out_data_next   = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = ev_ptr_reg;
        ram_wdata = '0;
        ram_raddr = ptr_reg;

        run_v       = run_reg;
        start_v     = start_reg;
        hit_v       = 1'b0;
        hit_start_v = '0;
        hit_page_v  = '0;
        page_v      = '0;
        mask_v      = '0;
        addr_wide_v = '0;
        end_word_v  = (state_reg == S_SCAN) ? LAST_WORD : lp_reg[PGW-1:BW];

        // output register drains independently of the sequencer
        if (out_vld_reg && !rsp_stall)
        begin
            out_vld_next = 1'b0;
        end

        // read issue for the word walks: one word a cycle up to end_word_v
        if ((state_reg == S_SCAN || state_reg == S_RMW) && !issue_done_reg)
        begin
            ev_vld_next = 1'b1;
            ev_ptr_next = ptr_reg;
            if (ptr_reg == end_word_v)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + AW'(1);
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                // wipe the map; page 0 stays reserved
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = (ptr_reg == '0) ? WORD_BITS'(1) : '0;
                if (ptr_reg == LAST_WORD)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data.req_type;
                    count_next = req_data.page_count;
                    first_next = req_data.byte_address[ADDR_W-1:PAGE_SHIFT];
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                rsp_next             = '0;
                rsp_next.status      = ST_OK;
                issue_done_next      = 1'b0;
                state_next           = S_RESP;
                case (req_reg)
                    REQ_ALLOC:
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = ST_NOFIT;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            run_next   = '0;
                            start_next = '0;
                            set_next   = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (first_out || (count_reg != '0 && last_out))
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else if (count_reg != '0)
                        begin
                            fp_next    = first_reg[PGW-1:0];
                            lp_next    = last_page[PGW-1:0];
                            ptr_next   = first_reg[PGW-1:BW];
                            set_next   = 1'b0;
                            state_next = S_RMW;
                        end
                    end
                    REQ_QUERY:
                    begin
                        if (first_out)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            ram_raddr  = first_reg[PGW-1:BW];
                            state_next = S_QBIT;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_NOFIT;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (ev_vld_reg)
                begin
                    // first fit across the eight pages of this word; pages past
                    // the zone end count as used
                    for (int i = 0; i < WORD_BITS; i++)
                    begin
                        page_v = {ev_ptr_reg, BW'(i)};
                        if (!hit_v)
                        begin
                            if (ram_rdata[i] || ({1'b0, page_v} >= (PGW+1)'(ZONE_PAGES)))
                            begin
                                run_v = '0;
                            end
                            else
                            begin
                                if (run_v == '0)
                                begin
                                    start_v = page_v;
                                end
                                run_v = run_v + COUNT_W'(1);
                            end
                            if (run_v == count_reg)
                            begin
                                hit_v       = 1'b1;
                                hit_start_v = start_v;
                                hit_page_v  = page_v;
                            end
                        end
                    end

                    run_next   = run_v;
                    start_next = start_v;

                    if (hit_v)
                    begin
                        addr_wide_v          = 64'(hit_start_v) << PAGE_SHIFT;
                        rsp_next.run_address = addr_wide_v[RUN_ADDR_W-1:0];
                        fp_next              = hit_start_v;
                        lp_next              = hit_page_v;
                        ptr_next             = hit_start_v[PGW-1:BW];
                        issue_done_next      = 1'b0;
                        ev_vld_next          = 1'b0;
                        state_next           = S_RMW;
                    end
                    else if (ev_ptr_reg == LAST_WORD)
                    begin
                        rsp_next.status = ST_NOFIT;
                        state_next      = S_RESP;
                    end
                end
            end

            S_RMW:
            begin
                if (ev_vld_reg)
                begin
                    for (int i = 0; i < WORD_BITS; i++)
                    begin
                        page_v    = {ev_ptr_reg, BW'(i)};
                        mask_v[i] = (page_v >= fp_reg) && (page_v <= lp_reg);
                    end
                    ram_we    = 1'b1;
                    ram_waddr = ev_ptr_reg;
                    ram_wdata = set_reg ? (ram_rdata | mask_v) : (ram_rdata & ~mask_v);
                    if (ev_ptr_reg == lp_reg[PGW-1:BW])
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_QBIT:
            begin
                rsp_next.page_in_use = ram_rdata[first_reg[BW-1:0]];
                state_next           = S_RESP;
            end

            S_RESP:
            begin
                if (!out_vld_reg || !rsp_stall)
                begin
                    out_data_next = rsp_reg;
                    out_vld_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= '0;
            issue_done_reg <= 1'b0;
            ev_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            issue_done_reg <= issue_done_next;
            ev_vld_reg     <= ev_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        count_reg    <= count_next;
        first_reg    <= first_next;
        ev_ptr_reg   <= ev_ptr_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        fp_reg       <= fp_next;
        lp_reg       <= lp_next;
        set_reg      <= set_next;
        rsp_reg      <= rsp_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
